FILE: rtl/core/key_debounce_autorepeat_assert.svh
// Assertion macros for the key debounce block.
`ifndef KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define KDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define KDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define KDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/kdar_pkg.sv
package kdar_pkg;

    localparam int NUM_KEYS  = 8;
    localparam int TICK_BITS = 16;
    localparam int CFG_W     = 16;
    localparam int MASK_W    = 8;
    localparam int CMP_W     = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_SETTLE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FIRST    = 2'd1;
    localparam logic [IDX_W-1:0] REG_REPEAT   = 2'd2;
    localparam logic [IDX_W-1:0] REG_MODMASK  = 2'd3;

    localparam logic [CFG_W-1:0]  RST_SETTLE  = 16'd20;
    localparam logic [CFG_W-1:0]  RST_FIRST   = 16'd500;
    localparam logic [CFG_W-1:0]  RST_REPEAT  = 16'd150;
    localparam logic [MASK_W-1:0] RST_MODMASK = 8'd0;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SETTLE = 4'b0010,
        PH_ACTIVE = 4'b0100,
        PH_HOLD   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] settle;
        logic [CFG_W-1:0] first;
        logic [CFG_W-1:0] repeat_p;
    } t_cfg;

    typedef struct packed {
        logic fire;
        logic mod_set;
        logic mod_clr;
    } t_key_evt;

endpackage

FILE: rtl/core/kdar_key.sv
module kdar_key import kdar_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_pressed,
    input  logic     i_is_mod,
    input  t_cfg     i_cfg,
    output t_key_evt o_evt
);

    t_phase                r_phase, n_phase;
    logic [TICK_BITS-1:0]  r_ticks, n_ticks;
    logic [TICK_BITS-1:0]  elapsed;
    logic [CMP_W-1:0]      elapsed_x;
    logic                  fire;
    logic                  release_held;

    assign elapsed   = (r_ticks == {TICK_BITS{1'b1}}) ? r_ticks : r_ticks + 1'b1;
    assign elapsed_x = CMP_W'(elapsed);

    always_comb begin
        n_phase      = r_phase;
        n_ticks      = elapsed;
        fire         = 1'b0;
        release_held = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_pressed) begin
                    n_phase = PH_SETTLE;
                    n_ticks = '0;
                end
            end
            PH_SETTLE: begin
                if (!i_pressed) begin
                    n_ticks = '0;
                end else if (elapsed_x > CMP_W'(i_cfg.settle)) begin
                    n_phase = PH_ACTIVE;
                    fire    = 1'b1;
                end
            end
            PH_ACTIVE: begin
                if (!i_pressed) begin
                    n_phase      = PH_IDLE;
                    n_ticks      = '0;
                    release_held = 1'b1;
                end else if (elapsed_x > CMP_W'(i_cfg.first)) begin
                    n_phase = PH_HOLD;
                    n_ticks = '0;
                    fire    = 1'b1;
                end
            end
            PH_HOLD: begin
                if (!i_pressed) begin
                    n_phase      = PH_IDLE;
                    n_ticks      = '0;
                    release_held = 1'b1;
                end else if (elapsed_x > CMP_W'(i_cfg.repeat_p)) begin
                    n_ticks = '0;
                    fire    = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_ticks = '0;
            end
        endcase
    end

    assign o_evt.fire    = i_en & fire;
    assign o_evt.mod_set = i_en & fire & i_is_mod;
    assign o_evt.mod_clr = i_en & release_held & i_is_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
        end
    end

`include "key_debounce_autorepeat_assert.svh"

    `KDA_ASSERT_IMP(a_fire_needs_press, i_clk, i_rst_n, o_evt.fire, i_en && i_pressed)
    `KDA_ASSERT_NXT(a_release_leaves_hold, i_clk, i_rst_n, i_en && !i_pressed, r_phase == PH_IDLE || r_phase == PH_SETTLE)
    `KDA_ASSERT_NXT(a_hold_when_idle, i_clk, i_rst_n, !i_en, $stable(r_ticks) && $stable(r_phase))

endmodule

FILE: rtl/core/key_debounce_autorepeat.sv
// Key debouncer with typematic auto-repeat.
// Input channel (i_valid / o_ready): one word per millisecond tick, i_key_levels holds
// the sampled level of every key, a zero bit meaning pressed.
// Output channel (o_valid / i_ready): one word per tick, o_fire marks the keys that fire
// on that tick and o_modifier_active is the shared modifier flag after it.
// A tick's result is registered and shows from the cycle after the tick is accepted.
// Throughput is one tick per cycle; all keys update in parallel in per-key lanes.
// The single output register is refilled in the cycle it is taken, so o_ready stays high
// as long as the receiver takes each result; while the receiver stalls with a result
// waiting, o_ready drops and the held result and key state stay unchanged.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx (0 settle ticks,
// 1 first-repeat ticks, 2 repeat ticks, 3 modifier mask) at once; write only when idle.
// Reset (synchronous, active low) returns every key to idle with its counter cleared,
// clears the modifier flag and the output valid flag (o_fire is not reset), and restores
// the register defaults 20, 500, 150 and 0.
module key_debounce_autorepeat import kdar_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [NUM_KEYS-1:0] i_key_levels,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [NUM_KEYS-1:0] o_fire,
    output logic                o_modifier_active,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_wdata
);

    t_cfg                r_cfg;
    logic [MASK_W-1:0]   r_mod_mask;
    logic                r_mod_flag, n_mod_flag;
    logic                r_out_valid;
    logic [NUM_KEYS-1:0] r_fire;
    logic                accept;
    t_key_evt            evt [NUM_KEYS];
    logic [NUM_KEYS-1:0] n_fire;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle   <= RST_SETTLE;
            r_cfg.first    <= RST_FIRST;
            r_cfg.repeat_p <= RST_REPEAT;
            r_mod_mask     <= RST_MODMASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SETTLE:  r_cfg.settle   <= i_cfg_wdata;
                REG_FIRST:   r_cfg.first    <= i_cfg_wdata;
                REG_REPEAT:  r_cfg.repeat_p <= i_cfg_wdata;
                REG_MODMASK: r_mod_mask     <= i_cfg_wdata[MASK_W-1:0];
                default:     ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        logic is_mod;
        if (k < MASK_W) begin : g_mask
            assign is_mod = r_mod_mask[k];
        end else begin : g_nomask
            assign is_mod = 1'b0;
        end

        kdar_key u_key (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (accept),
            .i_pressed (!i_key_levels[k]),
            .i_is_mod  (is_mod),
            .i_cfg     (r_cfg),
            .o_evt     (evt[k])
        );

        assign n_fire[k] = evt[k].fire;
    end

    // later keys override earlier ones
    always_comb begin
        n_mod_flag = r_mod_flag;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (evt[k].mod_set) begin
                n_mod_flag = 1'b1;
            end else if (evt[k].mod_clr) begin
                n_mod_flag = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_flag  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mod_flag  <= n_mod_flag;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fire <= n_fire;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_fire            = r_fire;
    assign o_modifier_active = r_mod_flag;

endmodule

FILE: tb/key_debounce_autorepeat_checker.sv
`timescale 1ns / 100ps

module key_debounce_autorepeat_checker import kdar_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [NUM_KEYS-1:0] i_key_levels,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [NUM_KEYS-1:0] i_fire,
    input  logic                i_modifier_active,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_reports,
    output int                  o_firings
);

    typedef struct packed {
        logic [NUM_KEYS-1:0] fire;
        logic                mod;
    } t_key_report;

    t_key_report          expected_reports[$];

    t_phase               key_ph  [NUM_KEYS];
    logic [TICK_BITS-1:0] key_cnt [NUM_KEYS];
    logic                 mod_flag;

    logic [CFG_W-1:0]     settle_cfg;
    logic [CFG_W-1:0]     first_cfg;
    logic [CFG_W-1:0]     repeat_cfg;
    logic [MASK_W-1:0]    mod_mask;

    int errs     = 0;
    int reports  = 0;
    int firings  = 0;

    // one tick across all keys, in key order so the last key to act owns the flag
    function automatic t_key_report advance_keys(input logic [NUM_KEYS-1:0] lv);
        t_key_report          rep;
        logic [TICK_BITS-1:0] nxt;
        logic                 pressed;
        logic                 is_mod;
        logic                 fired;
        rep = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            pressed = ~lv[k];
            is_mod  = (k < MASK_W) ? mod_mask[k] : 1'b0;
            fired   = 1'b0;
            nxt     = (key_cnt[k] == '1) ? key_cnt[k] : key_cnt[k] + 1'b1;
            case (key_ph[k])
                PH_IDLE: begin
                    if (pressed) begin
                        key_ph[k]  = PH_SETTLE;
                        key_cnt[k] = '0;
                    end else begin
                        key_cnt[k] = nxt;
                    end
                end
                PH_SETTLE: begin
                    if (!pressed) begin
                        key_cnt[k] = '0;
                    end else if (nxt > settle_cfg) begin
                        key_ph[k]  = PH_ACTIVE;
                        key_cnt[k] = nxt;
                        fired      = 1'b1;
                    end else begin
                        key_cnt[k] = nxt;
                    end
                end
                PH_ACTIVE: begin
                    if (!pressed) begin
                        key_ph[k]  = PH_IDLE;
                        key_cnt[k] = '0;
                        if (is_mod) mod_flag = 1'b0;
                    end else if (nxt > first_cfg) begin
                        key_ph[k]  = PH_HOLD;
                        key_cnt[k] = '0;
                        fired      = 1'b1;
                    end else begin
                        key_cnt[k] = nxt;
                    end
                end
                default: begin
                    if (!pressed) begin
                        key_ph[k]  = PH_IDLE;
                        key_cnt[k] = '0;
                        if (is_mod) mod_flag = 1'b0;
                    end else if (nxt > repeat_cfg) begin
                        key_cnt[k] = '0;
                        fired      = 1'b1;
                    end else begin
                        key_cnt[k] = nxt;
                    end
                end
            endcase
            if (fired) begin
                rep.fire[k] = 1'b1;
                if (is_mod) mod_flag = 1'b1;
            end
        end
        rep.mod = mod_flag;
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch
        t_key_report want;
        if (!i_rst_n) begin
            expected_reports.delete();
            for (int k = 0; k < NUM_KEYS; k++) begin
                key_ph[k]  = PH_IDLE;
                key_cnt[k] = '0;
            end
            mod_flag   = 1'b0;
            settle_cfg = RST_SETTLE;
            first_cfg  = RST_FIRST;
            repeat_cfg = RST_REPEAT;
            mod_mask   = RST_MODMASK;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_reports.push_back(advance_keys(i_key_levels));

            if (i_out_valid && i_out_ready) begin
                reports++;
                firings += $countones(i_fire);
                if (expected_reports.size() == 0) begin
                    $error("result word with no tick waiting: fire %h, modifier_active %b",
                           i_fire, i_modifier_active);
                    errs++;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_fire !== want.fire) begin
                        $error("fire: expected %h, actual %h", want.fire, i_fire);
                        errs++;
                    end
                    if (i_modifier_active !== want.mod) begin
                        $error("modifier_active: expected %b, actual %b",
                               want.mod, i_modifier_active);
                        errs++;
                    end
                end
            end

            // register writes land after the tick taken on the same edge
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SETTLE:  settle_cfg = i_cfg_wdata;
                    REG_FIRST:   first_cfg  = i_cfg_wdata;
                    REG_REPEAT:  repeat_cfg = i_cfg_wdata;
                    REG_MODMASK: mod_mask   = i_cfg_wdata[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= errs;
        o_pending <= expected_reports.size();
        o_reports <= reports;
        o_firings <= firings;
    end

endmodule

FILE: tb/key_debounce_autorepeat_tb.sv
`timescale 1ns / 100ps

module key_debounce_autorepeat_tb;
    import kdar_pkg::*;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic [NUM_KEYS-1:0] i_key_levels = '1;
    logic                i_ready      = 1'b0;
    logic                i_cfg_we     = 1'b0;
    logic [IDX_W-1:0]    i_cfg_idx    = REG_SETTLE;
    logic [CFG_W-1:0]    i_cfg_wdata  = '0;

    logic                o_ready;
    logic                o_valid;
    logic [NUM_KEYS-1:0] o_fire;
    logic                o_modifier_active;

    int errors;
    int pending;
    int reports;
    int firings;

    int  ticks_sent = 0;
    int  settings   = 0;
    int  rx_wait    = 0;
    int  rx_taken   = 0;
    bit  quiet      = 1'b0;
    logic [NUM_KEYS-1:0] held = '1;

    logic [NUM_KEYS-1:0] dir_a [0:15] = '{
        8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFE,
        8'h00, 8'h55, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h01, 8'h80
    };
    // settle release restart, then fire, repeat and release on key 0
    logic [NUM_KEYS-1:0] dir_b [0:8] = '{
        8'hFE, 8'hFF, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFE, 8'hFF
    };

    always #5 i_clk = ~i_clk;

    key_debounce_autorepeat dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_key_levels      (i_key_levels),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_fire            (o_fire),
        .o_modifier_active (o_modifier_active),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    key_debounce_autorepeat_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_key_levels      (i_key_levels),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_fire            (o_fire),
        .i_modifier_active (o_modifier_active),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_reports         (reports),
        .o_firings         (firings)
    );

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random gaps, plus two long hold-offs to back the block up
    always @(posedge i_clk) begin : rx_side
        int gap;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_wait <= 0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_ready <= (rx_wait == 1);
        end else if (o_valid && i_ready) begin
            rx_taken <= rx_taken + 1;
            if (rx_taken == 300 || rx_taken == 1300) begin
                rx_wait <= 200;
                i_ready <= 1'b0;
            end else begin
                gap = pick_gap();
                rx_wait <= gap;
                i_ready <= (gap == 0);
            end
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic put_word(input logic [NUM_KEYS-1:0] lv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_key_levels <= lv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] f,
                                 input logic [CFG_W-1:0] r, input logic [MASK_W-1:0] m);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_SETTLE;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        i_cfg_idx   <= REG_FIRST;
        i_cfg_wdata <= f;
        @(posedge i_clk);
        i_cfg_idx   <= REG_REPEAT;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_idx   <= REG_MODMASK;
        i_cfg_wdata <= CFG_W'(m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings++;
    endtask

    // mostly held keys that toggle now and then, with bounces and random words
    task automatic run_keys(input int count, input int flip_div, input int noise_pct);
        int r;
        logic [NUM_KEYS-1:0] w;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < noise_pct) begin
                w = NUM_KEYS'($urandom);
            end else if (r < 2 * noise_pct) begin
                w = held ^ (NUM_KEYS'(1) << $urandom_range(0, NUM_KEYS - 1));
            end else begin
                for (int k = 0; k < NUM_KEYS; k++)
                    if ($urandom_range(1, flip_div) == 1) held[k] = ~held[k];
                w = held;
            end
            put_word(w);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_settings(16'd0, 16'd1, 16'd0, 8'hAA);
        foreach (dir_a[j]) put_word(dir_a[j]);
        load_settings(16'd2, 16'd3, 16'd1, 8'h01);
        foreach (dir_b[j]) put_word(dir_b[j]);

        load_settings(RST_SETTLE, RST_FIRST, RST_REPEAT, RST_MODMASK);
        run_keys(600, 500, 0);
        load_settings(16'd0, 16'd0, 16'd0, 8'hFF);
        run_keys(250, 6, 5);
        load_settings(16'd3, 16'd12, 16'd5, MASK_W'($urandom));
        run_keys(300, 25, 4);
        // thresholds at maximum never get exceeded
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h0F);
        run_keys(100, 10, 5);
        load_settings(16'd1, 16'd65534, 16'd65534, 8'hF0);
        run_keys(100, 8, 3);
        load_settings(16'd65534, 16'd2, 16'd0, 8'h81);
        run_keys(60, 8, 5);
        repeat (3) begin
            load_settings(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 60)),
                          CFG_W'($urandom_range(0, 20)), MASK_W'($urandom));
            run_keys(150, 40, 3);
        end

        drain();
        repeat (5) @(posedge i_clk);
        $display("Ran %0d ticks under %0d register settings, with long receiver stalls.",
                 ticks_sent, settings);
        $display("Checked %0d result words carrying %0d key firings.", reports, firings);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d result words outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule
